>>> rtl/bfnl_pkg.sv
// ----------------------------------------------------------------------------
// bfnl_pkg
// shared types, codes and constants of the backward function name locator
// ----------------------------------------------------------------------------
package bfnl_pkg;

  // lookup phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WORD = 2'd1,
    PH_BYTE = 2'd2
  } phase_e;

  // result kind, travels on the master-side tuser
  typedef enum logic [1:0] {
    KIND_WORD = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_DONE = 2'd2
  } out_kind_e;

  // request type, travels on the slave-side tuser
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_RESP  = 1'b1;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_SEARCH_LIMIT = 2'd0;
  localparam logic [1:0] REG_MIN_NAME_LEN = 2'd1;
  localparam logic [1:0] REG_MAX_NAME_LEN = 2'd2;

  // register reset values
  localparam logic [15:0] SEARCH_LIMIT_RST = 16'd32768;
  localparam logic [6:0]  MIN_NAME_LEN_RST = 7'd4;
  localparam logic [6:0]  MAX_NAME_LEN_RST = 7'd64;

  // marker word and name limits
  localparam logic [7:0]  MARKER_BYTE = 8'hff;
  localparam logic [6:0]  NAME_CAP    = 7'd64;
  localparam logic [6:0]  PAD_SLACK   = 7'd4;
  localparam logic [16:0] WORD_STEP   = 17'd4;
  localparam logic [16:0] OFFSET_MAX  = 17'h0ffff;

  // one result item
  typedef struct packed {
    logic [6:0]  name_length;
    logic [31:0] name_address;
    logic        found;
    logic [31:0] read_address;
    out_kind_e   kind;
  } result_t;

  // letters and underscore anywhere, digits anywhere but the first position
  function automatic logic char_ok(input logic [7:0] c, input logic first);
    logic digit;
    logic alpha;
    digit = (c >= 8'h30) && (c <= 8'h39);
    alpha = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    return (digit && !first) || alpha || (c == 8'h5f);
  endfunction

endpackage

>>> rtl/backward_function_name_locator.sv
// ----------------------------------------------------------------------------
// backward_function_name_locator
// walks backward from a code address looking for a name marker word and
// checks the name string stored in front of it
// ----------------------------------------------------------------------------
// a transaction accepted on the slave side sits in the input register; its
//   result, if it has one, is loaded into the result register once that is
//   empty or being drained, and is then offered on the master side
// throughput: one transaction per cycle unless the master side stalls; each response
//   is judged by one pass of compare logic between the input and result registers
// reset: rst_ni is asynchronous, active low; it empties both registers, sets
//   the phase to idle and loads the register defaults (32768, 4, 64)
module backward_function_name_locator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [31:0] start_address, [63:32] read_data, [64] read_ok, [71:65] zero
  input  logic [71:0] s_axis_tdata_i,
  // [0] req_type
  input  logic        s_axis_tuser_i,
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] read_address, [32] found, [64:33] name_address, [71:65] name_length
  output logic [71:0] m_axis_tdata_o,
  // [1:0] out_kind
  output logic [1:0]  m_axis_tuser_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bfnl_pkg::*;

  // configuration registers
  logic [15:0] limit_q;
  logic [6:0]  min_len_q;
  logic [6:0]  max_len_q;
  logic        cfg_wr;

  // input register
  logic        in_valid_q;
  logic        in_req_q;
  logic [31:0] in_addr_q;
  logic [31:0] in_data_q;
  logic        in_ok_q;

  // result register
  logic        out_valid_q;
  result_t     out_q;

  // lookup state
  phase_e      phase_q, phase_d;
  logic [31:0] base_q, base_d;
  logic [15:0] off_q, off_d;
  logic [6:0]  pad_q, pad_d;
  logic [6:0]  chars_q, chars_d;
  logic [31:0] name_q, name_d;   // name start, kept from the marker hit

  logic        advance;
  logic        res_valid;
  result_t     res;
  logic        do_next;

  // datapath terms
  logic [6:0]  eff_max;
  logic [7:0]  size_cap;
  logic [31:0] here;
  logic [23:0] size;
  logic [16:0] next_off;
  logic [7:0]  byte_c;
  logic [6:0]  slack;
  logic [6:0]  chars_inc;

  // --------------------------------------------------------------------------
  // configuration port: writes land on the access cycle, pready tied high
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= SEARCH_LIMIT_RST;
      min_len_q <= MIN_NAME_LEN_RST;
      max_len_q <= MAX_NAME_LEN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SEARCH_LIMIT: limit_q   <= pwdata[15:0];
        REG_MIN_NAME_LEN: min_len_q <= pwdata[6:0];
        REG_MAX_NAME_LEN: max_len_q <= pwdata[6:0];
        default: ;  // no register here, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SEARCH_LIMIT: prdata = {16'd0, limit_q};
      REG_MIN_NAME_LEN: prdata = {25'd0, min_len_q};
      REG_MAX_NAME_LEN: prdata = {25'd0, max_len_q};
      default:          prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // handshake: the held transaction moves on whenever the result register is
  // empty or being drained, so ready stays high under a steady flow
  // --------------------------------------------------------------------------
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_req_q  <= s_axis_tuser_i;
      in_addr_q <= s_axis_tdata_i[31:0];
      in_data_q <= s_axis_tdata_i[63:32];
      in_ok_q   <= s_axis_tdata_i[64];
    end
  end

  // --------------------------------------------------------------------------
  // single pass judgement of the held transaction
  // --------------------------------------------------------------------------
  // longest name clamps at the cap, padded size may run four past it
  assign eff_max   = (max_len_q > NAME_CAP) ? NAME_CAP : max_len_q;
  assign size_cap  = {1'b0, eff_max} + {1'b0, PAD_SLACK};
  assign here      = base_q - {16'd0, off_q};
  assign size      = in_data_q[23:0];
  assign next_off  = {1'b0, off_q} + WORD_STEP;
  assign byte_c    = in_data_q[7:0];
  assign slack     = pad_q - chars_q;   // chars stay below the padded size
  assign chars_inc = chars_q + 7'd1;

  always_comb begin
    phase_d   = phase_q;
    base_d    = base_q;
    off_d     = off_q;
    pad_d     = pad_q;
    chars_d   = chars_q;
    name_d    = name_q;
    res_valid = 1'b0;
    res       = '0;
    do_next   = 1'b0;

    if (in_req_q == REQ_START) begin
      // a start abandons any running lookup
      base_d    = {in_addr_q[31:2], 2'b00};
      off_d     = 16'd0;
      pad_d     = 7'd0;
      chars_d   = 7'd0;
      res_valid = 1'b1;
      if (limit_q == 16'd0) begin
        phase_d  = PH_IDLE;
        res.kind = KIND_DONE;
      end else begin
        phase_d          = PH_WORD;
        res.kind         = KIND_WORD;
        res.read_address = {in_addr_q[31:2], 2'b00};
      end
    end else begin
      unique case (phase_q)
        PH_WORD: begin
          if (!in_ok_q) begin
            // a faulted word read ends the lookup
            phase_d   = PH_IDLE;
            res_valid = 1'b1;
            res.kind  = KIND_DONE;
          end else if (in_data_q[31:24] != MARKER_BYTE) begin
            do_next = 1'b1;
          end else if (({8'd0, size} > here) || (size > {16'd0, size_cap}) ||
                       (size < {17'd0, min_len_q}) || (size == 24'd0)) begin
            do_next = 1'b1;
          end else begin
            // plausible marker: fetch the first name byte
            pad_d            = size[6:0];
            chars_d          = 7'd0;
            name_d           = here - {8'd0, size};
            phase_d          = PH_BYTE;
            res_valid        = 1'b1;
            res.kind         = KIND_BYTE;
            res.read_address = here - {8'd0, size};
          end
        end
        PH_BYTE: begin
          if (!in_ok_q) begin
            do_next = 1'b1;
          end else if (byte_c == 8'd0) begin
            // terminator: check padding and length
            if ((slack > PAD_SLACK) || (chars_q < min_len_q) || (chars_q > eff_max)) begin
              do_next = 1'b1;
            end else begin
              phase_d          = PH_IDLE;
              res_valid        = 1'b1;
              res.kind         = KIND_DONE;
              res.found        = 1'b1;
              res.name_address = name_q;
              res.name_length  = chars_q;
            end
          end else if (!char_ok(byte_c, chars_q == 7'd0)) begin
            do_next = 1'b1;
          end else begin
            chars_d = chars_inc;
            if (chars_inc >= pad_q) begin
              // no terminator inside the padded size
              do_next = 1'b1;
            end else begin
              res_valid        = 1'b1;
              res.kind         = KIND_BYTE;
              res.read_address = name_q + {25'd0, chars_inc};
            end
          end
        end
        default: ;  // response while idle is dropped
      endcase
    end

    // step one word further back, or finish when the window is used up
    if (do_next) begin
      res_valid = 1'b1;
      if (next_off > OFFSET_MAX) begin
        phase_d  = PH_IDLE;
        res.kind = KIND_DONE;
      end else begin
        off_d = next_off[15:0];
        if ((next_off[15:0] >= limit_q) || ({15'd0, next_off} > base_q)) begin
          phase_d  = PH_IDLE;
          res.kind = KIND_DONE;
        end else begin
          phase_d          = PH_WORD;
          res.kind         = KIND_WORD;
          res.read_address = base_q - {15'd0, next_off};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      base_q  <= 32'd0;
      off_q   <= 16'd0;
      pad_q   <= 7'd0;
      chars_q <= 7'd0;
    end else if (advance) begin
      phase_q <= phase_d;
      base_q  <= base_d;
      off_q   <= off_d;
      pad_q   <= pad_d;
      chars_q <= chars_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      name_q <= name_d;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {out_q.name_length, out_q.name_address, out_q.found,
                            out_q.read_address};

`ifndef SYNTHESIS
  // read requests never claim a hit, misses carry no name
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !out_q.found |->
      (out_q.name_address == 32'd0) && (out_q.name_length == 7'd0))
    else $error("miss result carries a name");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (out_q.kind != KIND_DONE) |-> !out_q.found)
    else $error("read request flagged as found");

  // byte scan never runs past the padded size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BYTE |-> chars_q < pad_q)
    else $error("byte scan past padded size");

  // a finish result always leaves the lookup idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_valid && (res.kind == KIND_DONE) |=> phase_q == PH_IDLE)
    else $error("lookup still busy after finish");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives lookups and memory read responses into the backward name locator,
// answers its read requests from a small planned memory image, and checks
// every request and finish transaction against an in-bench prediction
// ----------------------------------------------------------------------------
module testbench;
  import bfnl_pkg::*;

  localparam int HOLD_OFF       = 250;   // long receiver stall, in cycles
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction at all
  localparam int IMAGE_BYTES    = 80;    // name plus padding, worst case 72

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  // slave side
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [31:0] start_address, [63:32] read_data, [64] read_ok, [71:65] zero
  logic [71:0] s_tdata  = '0;
  // [0] req_type
  logic        s_tuser  = 1'b0;
  // master side
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [31:0] read_address, [32] found, [64:33] name_address, [71:65] name_length
  logic [71:0] m_tdata;
  // [1:0] out_kind
  logic [1:0]  m_tuser;
  // configuration port
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  backward_function_name_locator dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // --------------------------------------------------------------------------
  // shared run state
  // --------------------------------------------------------------------------
  logic idling           = 1'b1;  // random gaps on both sides
  logic hold_off_request = 1'b0;  // asks the receiver for one long stall
  int   mismatches       = 0;
  int   quiet_cycles     = 0;

  // lookup predictor: register copies and walk state
  logic [15:0] cfg_limit = SEARCH_LIMIT_RST;
  logic [6:0]  cfg_min   = MIN_NAME_LEN_RST;
  logic [6:0]  cfg_max   = MAX_NAME_LEN_RST;
  phase_e      walk_phase   = PH_IDLE;
  logic [31:0] walk_base    = '0;
  logic [31:0] walk_off     = '0;
  logic [31:0] walk_pad     = '0;
  logic [31:0] walk_chars   = '0;
  logic [31:0] walk_read_at = '0;  // address of the latest predicted read
  int          results_predicted = 0;
  result_t     lookup_outputs_q[$];

  // planned memory image for the running lookup
  logic [31:0] img_marker_at;
  logic [31:0] img_marker_word;
  logic [31:0] img_name_at;
  logic [7:0]  img_bytes [IMAGE_BYTES];

  // letters and underscore first, digits from index 53 on
  string name_alphabet = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  // characters just outside the legal ranges, plus a few others
  string odd_chars     = "/:@[`{-. ~";

  // --------------------------------------------------------------------------
  // reporting
  // --------------------------------------------------------------------------
  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s: expected %h, got %h", what, want, got);
  endfunction

  // --------------------------------------------------------------------------
  // lookup predictor
  // --------------------------------------------------------------------------
  function automatic logic [31:0] eff_max_len();
    return (cfg_max > NAME_CAP) ? 32'(NAME_CAP) : 32'(cfg_max);
  endfunction

  function automatic logic name_char_legal(input logic [7:0] c, input logic leading);
    if (c == "_") return 1'b1;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return 1'b1;
    return !leading && (c >= "0") && (c <= "9");
  endfunction

  function automatic void queue_output(input out_kind_e kind, input logic [31:0] raddr,
                                       input logic fnd, input logic [31:0] naddr,
                                       input logic [6:0] nlen);
    result_t r;
    r.kind         = kind;
    r.read_address = raddr;
    r.found        = fnd;
    r.name_address = naddr;
    r.name_length  = nlen;
    lookup_outputs_q.push_back(r);
    walk_read_at = raddr;
    results_predicted++;
  endfunction

  function automatic void finish_lookup(input logic fnd, input logic [31:0] naddr,
                                        input logic [6:0] nlen);
    walk_phase = PH_IDLE;
    queue_output(KIND_DONE, '0, fnd, naddr, nlen);
  endfunction

  // read the word at the current distance, or give up when out of range
  function automatic void request_word();
    if (walk_off >= 32'(cfg_limit) || walk_off > walk_base) begin
      finish_lookup(1'b0, '0, '0);
    end else begin
      walk_phase = PH_WORD;
      queue_output(KIND_WORD, walk_base - walk_off, 1'b0, '0, '0);
    end
  endfunction

  function automatic void advance_word();
    logic [31:0] nxt;
    nxt = walk_off + 32'd4;
    if (nxt > 32'h0000_ffff) begin
      finish_lookup(1'b0, '0, '0);
    end else begin
      walk_off = nxt;
      request_word();
    end
  endfunction

  function automatic void lookup_step(input logic req, input logic [31:0] start_addr,
                                      input logic [31:0] rdata, input logic rok);
    logic [31:0] here;
    logic [31:0] size;
    logic [31:0] name_at;
    logic [7:0]  c;
    if (req == REQ_START) begin
      // a start always wins, even over a running lookup
      walk_base  = {start_addr[31:2], 2'b00};
      walk_off   = '0;
      walk_pad   = '0;
      walk_chars = '0;
      request_word();
    end else if (walk_phase == PH_WORD) begin
      here = walk_base - walk_off;
      size = {8'h00, rdata[23:0]};
      if (!rok) begin
        finish_lookup(1'b0, '0, '0);
      end else if (rdata[31:24] != MARKER_BYTE) begin
        advance_word();
      end else if (size > here || size > eff_max_len() + 32'(PAD_SLACK) ||
                   size < 32'(cfg_min) || size == 0) begin
        advance_word();
      end else begin
        walk_pad   = size;
        walk_chars = '0;
        walk_phase = PH_BYTE;
        queue_output(KIND_BYTE, here - size, 1'b0, '0, '0);
      end
    end else if (walk_phase == PH_BYTE) begin
      name_at = walk_base - walk_off - walk_pad;
      c       = rdata[7:0];
      if (!rok) begin
        advance_word();
      end else if (c == 8'h00) begin
        // terminator: padding, then length limits
        if (walk_pad - walk_chars > 32'(PAD_SLACK) || walk_chars < 32'(cfg_min) ||
            walk_chars > eff_max_len())
          advance_word();
        else
          finish_lookup(1'b1, name_at, walk_chars[6:0]);
      end else if (!name_char_legal(c, walk_chars == 0)) begin
        advance_word();
      end else begin
        walk_chars = walk_chars + 1;
        if (walk_chars >= walk_pad)
          advance_word();
        else
          queue_output(KIND_BYTE, name_at + walk_chars, 1'b0, '0, '0);
      end
    end
    // a response while idle causes nothing
  endfunction

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (lookup_outputs_q.size() == 0) begin
        flag_mismatch("unexpected transaction", '0, m_tdata[31:0]);
      end else begin
        want = lookup_outputs_q.pop_front();
        if (m_tuser !== want.kind)
          flag_mismatch("out_kind", 32'(want.kind), 32'(m_tuser));
        if (m_tdata[31:0] !== want.read_address)
          flag_mismatch("read_address", want.read_address, m_tdata[31:0]);
        if (m_tdata[32] !== want.found)
          flag_mismatch("found", 32'(want.found), 32'(m_tdata[32]));
        if (m_tdata[64:33] !== want.name_address)
          flag_mismatch("name_address", want.name_address, m_tdata[64:33]);
        if (m_tdata[71:65] !== want.name_length)
          flag_mismatch("name_length", 32'(want.name_length), 32'(m_tdata[71:65]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stall bursts, and one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        m_tready <= 1'b0;
        for (n = 1; n < HOLD_OFF; n++) @(posedge clk);
      end else if (idling && $urandom_range(9, 0) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(17, 1) - 1) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: ends the run after a long stretch with no transaction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender and register access
  // --------------------------------------------------------------------------
  // offers one transaction, possibly after a gap, and predicts once it is taken
  task automatic offer_transaction(input logic req, input logic [31:0] start_addr,
                                   input logic [31:0] rdata, input logic rok);
    if (idling && $urandom_range(9, 0) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {7'b0, rok, rdata, start_addr};
    do @(posedge clk); while (!s_tready);
    lookup_step(req, start_addr, rdata, rok);
  endtask

  task automatic start_lookup(input logic [31:0] addr);
    offer_transaction(REQ_START, addr, $urandom, 1'($urandom));
  endtask

  task automatic deliver(input logic [31:0] data, input logic ok);
    offer_transaction(REQ_RESP, $urandom, data, ok);
  endtask

  // waits until every predicted transaction has come back, plus the pipeline
  task automatic wait_for_quiet();
    s_tvalid <= 1'b0;
    while (lookup_outputs_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic read_reg(input logic [1:0] idx, input logic [31:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      flag_mismatch("register read-back", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // writes one register, then reads it back
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SEARCH_LIMIT: cfg_limit = value[15:0];
      REG_MIN_NAME_LEN: cfg_min   = value[6:0];
      REG_MAX_NAME_LEN: cfg_max   = value[6:0];
      default: ;
    endcase
    read_reg(idx, value);
  endtask

  task automatic set_registers(input logic [15:0] limit, input logic [6:0] min_len,
                               input logic [6:0] max_len);
    wait_for_quiet();
    write_reg(REG_SEARCH_LIMIT, 32'(limit));
    write_reg(REG_MIN_NAME_LEN, 32'(min_len));
    write_reg(REG_MAX_NAME_LEN, 32'(max_len));
  endtask

  // --------------------------------------------------------------------------
  // memory image and read responder
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pick_name_char(input logic leading);
    return name_alphabet[$urandom_range(leading ? 52 : 62, 0)];
  endfunction

  // any word whose top byte does not mark a name
  function automatic logic [31:0] plain_word();
    logic [31:0] w;
    w = $urandom;
    if (w[31:24] == MARKER_BYTE) w[31] = 1'b0;
    return w;
  endfunction

  // places a marker up to six words below the base, a name in front of it, and
  // now and then one defect that should make the block reject the name
  task automatic plan_image(input logic [31:0] base);
    int lo, hi, len, pad, defect, k;
    img_marker_at = base - 32'(4 * $urandom_range(6, 0));
    lo = int'(cfg_min);
    hi = int'(eff_max_len());
    if (lo <= hi) begin
      // mostly short names, now and then up to the limit
      if ($urandom_range(3, 0) != 0 && lo + 6 < hi) hi = lo + 6;
      len = $urandom_range(hi, lo);
    end else begin
      len = $urandom_range(64, 0);
    end
    pad    = len + $urandom_range(4, 1);
    defect = $urandom_range(7, 0);
    if (defect == 3) pad = len + $urandom_range(8, 5);  // padding too long
    for (k = 0; k < IMAGE_BYTES; k++)
      img_bytes[k] = (k < len) ? pick_name_char(k == 0) : 8'($urandom);
    img_bytes[len] = 8'h00;
    case (defect)
      0: if (len > 0)
           img_bytes[$urandom_range(len - 1, 0)] = ($urandom_range(2, 0) == 0) ?
             8'($urandom_range(255, 128)) : odd_chars[$urandom_range(odd_chars.len() - 1, 0)];
      1: if (len > 0) img_bytes[0] = name_alphabet[$urandom_range(62, 53)];  // digit first
      2: img_bytes[len] = pick_name_char(1'b0);  // terminator missing
      default: ;
    endcase
    img_marker_word = {MARKER_BYTE, 24'(pad)};
    if (defect == 4) img_marker_word[23:0] = 24'($urandom);  // size field garbage
    img_name_at = img_marker_at - 32'(pad);
  endtask

  // answers the block's latest read request from the image
  task automatic answer_request();
    logic [31:0] data;
    logic [31:0] spot;
    logic        ok;
    ok = ($urandom_range(39, 0) != 0);
    if (walk_phase == PH_WORD) begin
      if (walk_read_at == img_marker_at)
        data = img_marker_word;
      else if ($urandom_range(9, 0) == 0)
        data = {MARKER_BYTE, 24'($urandom_range(80, 0))};  // stray marker
      else
        data = plain_word();
    end else begin
      spot = walk_read_at - img_name_at;
      data = $urandom;  // upper bits of a byte response carry junk
      if (spot < IMAGE_BYTES) data[7:0] = img_bytes[spot];
    end
    deliver(data, ok);
  endtask

  // well-formed lookups with random content; some are abandoned by a new
  // start, and stray responses follow some finished ones
  task automatic run_lookups(input int n_results);
    int          goal;
    int          steps;
    logic [31:0] base;
    goal = results_predicted + n_results;
    while (results_predicted < goal) begin
      case ($urandom_range(3, 0))
        0:       base = $urandom_range(96, 0);
        1:       base = 32'hffff_ffff - $urandom_range(96, 0);
        default: base = $urandom;
      endcase
      plan_image({base[31:2], 2'b00});
      start_lookup(base);
      steps = 0;
      while (walk_phase != PH_IDLE && steps < 90 && $urandom_range(39, 0) != 0) begin
        answer_request();
        steps++;
      end
      if (walk_phase == PH_IDLE && $urandom_range(5, 0) == 0)
        deliver($urandom, 1'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_reset_values();
    read_reg(REG_SEARCH_LIMIT, 32'(SEARCH_LIMIT_RST));
    read_reg(REG_MIN_NAME_LEN, 32'(MIN_NAME_LEN_RST));
    read_reg(REG_MAX_NAME_LEN, 32'(MAX_NAME_LEN_RST));
  endtask

  // hand-made sequences under the reset register values
  task automatic test_directed();
    deliver(32'hffff_ffff, 1'b1);        // response with no lookup running
    // top of the address space, name found right in front of the marker
    start_lookup(32'hffff_ffff);
    deliver(32'hff00_0006, 1'b1);
    deliver(32'hffff_ff5f, 1'b1);        // underscore, junk in the upper bits
    deliver(32'h0000_0061, 1'b1);
    deliver(32'h0000_0039, 1'b1);        // digit after the first position
    deliver(32'h0000_005a, 1'b1);
    deliver(32'h0000_0000, 1'b1);
    // lowest addresses: search stops at address zero
    start_lookup(32'h0000_0003);
    deliver(32'h0000_0000, 1'b1);
    // faulted word read ends the lookup
    start_lookup(32'h0000_1000);
    deliver(32'hff00_0004, 1'b0);
    // digit in the first position rejects the name
    start_lookup(32'h0000_2000);
    deliver(32'hff00_0005, 1'b1);
    deliver(32'h0000_0031, 1'b1);
    // new start abandons the running lookup
    start_lookup(32'h0000_3004);
    deliver(32'hff00_0044, 1'b1);        // largest padded size that passes
    deliver(32'h0000_0078, 1'b0);        // faulted byte read moves on
    deliver(32'hff00_0045, 1'b1);        // one over the padded size limit
    deliver(32'h00ff_ffff, 1'b1);
    deliver(32'hff00_0004, 1'b1);
    deliver(32'h0000_0051, 1'b1);
    deliver(32'h0000_002d, 1'b1);        // illegal character
    wait_for_quiet();
  endtask

  // corner register settings, each with a batch of lookups
  task automatic test_register_settings();
    set_registers(16'd4, 7'd1, 7'd1);
    run_lookups(40);
    set_registers(16'd0, 7'd4, 7'd64);   // every lookup ends at once
    run_lookups(30);
    set_registers(16'd40, 7'd64, 7'd64);
    run_lookups(40);
    set_registers(16'd32768, 7'd0, 7'd127);  // no lower bound, max length above the cap of 64
    run_lookups(40);
    set_registers(16'd12, 7'd127, 7'd0);
    run_lookups(40);
    set_registers(16'd100, 7'd0, 7'd0);  // empty names only
    run_lookups(40);
  endtask

  task automatic test_random_lookups();
    int          n;
    logic [6:0]  min_len;
    logic [15:0] limit;
    for (n = 0; n < 5; n++) begin
      limit   = ($urandom_range(2, 0) == 0) ? 16'd32768 : 16'($urandom_range(96, 4));
      min_len = 7'($urandom_range(10, 1));
      set_registers(limit, min_len, 7'($urandom_range(64, 1)));
      run_lookups(80);
    end
  endtask

  // receiver stalls for a long stretch while lookups keep coming
  task automatic test_backpressure();
    set_registers(16'd64, 7'd2, 7'd16);
    hold_off_request = 1'b1;
    run_lookups(60);
    wait_for_quiet();
  endtask

  // stretch with no plausible marker: the walk runs until the search window is used up
  task automatic test_long_walk();
    set_registers(16'd128, 7'd1, 7'd64);
    start_lookup(32'hffff_ffff);
    while (walk_phase != PH_IDLE)
      deliver(($urandom_range(63, 0) == 0) ? 32'hff7f_ffff : plain_word(), 1'b1);
    wait_for_quiet();
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin : sequencer
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_reset_values();
    test_directed();
    test_register_settings();
    test_random_lookups();
    test_backpressure();
    idling = 1'b0;  // the last stretch runs without gaps
    test_long_walk();
    wait_for_quiet();
    repeat (8) @(posedge clk);  // catch any late transaction
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
